>>> rtl/glm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glm_pkg: shared types and constants of the gauge limit monitor
// Field widths, request/result packing, the edit-mode state type and the
// saturating limit step used by the limit editor.
// ----------------------------------------------------------------------------
package glm_pkg;

   // field widths
   localparam int POS_W       = 24;
   localparam int GAIN_W      = 32;
   localparam int SCALED_W    = 40;
   localparam int MEAS_W      = 41;
   localparam int LIM_W       = 32;
   localparam int DELTA_W     = 5;
   localparam int QUOT_W      = 29;
   localparam int IN_TDATA_W  = 32;
   localparam int OUT_TDATA_W = 192;

   // gain reset value: 1.0 in Q16.16
   localparam logic [GAIN_W-1:0] GAIN_RESET = 32'h0001_0000;

   // divide by ten: q = (x * RECIP10) >> RECIP_SHIFT, exact for any 32-bit x
   localparam logic [LIM_W-1:0] RECIP10     = 32'hCCCC_CCCD;
   localparam int               RECIP_SHIFT = 35;

   // zone codes
   localparam logic [1:0] ZONE_GREEN  = 2'd0;
   localparam logic [1:0] ZONE_YELLOW = 2'd1;
   localparam logic [1:0] ZONE_RED    = 2'd2;

   // edit state codes as shown on the result
   localparam logic [1:0] EDIT_CODE_IDLE = 2'd0;
   localparam logic [1:0] EDIT_CODE_HIGH = 2'd1;
   localparam logic [1:0] EDIT_CODE_LOW  = 2'd2;

   // request tdata bit positions
   localparam int IN_MODE_BIT  = 24;
   localparam int IN_TARE_BIT  = 25;
   localparam int IN_CLICK_BIT = 26;
   localparam int IN_R_BIT     = 27;
   localparam int IN_L_BIT     = 28;
   localparam int IN_RH_BIT    = 29;
   localparam int IN_LH_BIT    = 30;

   // limit editor state
   typedef enum logic [2:0] {
      EDIT_IDLE = 3'b001,
      EDIT_HIGH = 3'b010,
      EDIT_LOW  = 3'b100
   } edit_type;

   // button and knob events of one request
   typedef struct packed {
      logic mode_click;
      logic tare_click;
      logic knob_click;
      logic knob_right;
      logic knob_left;
      logic knob_right_held;
      logic knob_left_held;
   } evt_type;

   // tracker result handed to the zone stages
   typedef struct packed {
      logic signed [MEAS_W-1:0] measured;
      logic signed [MEAS_W-1:0] peak_high;
      logic signed [MEAS_W-1:0] peak_low;
      logic        [1:0]        edit_state;
      logic                     dynamic_on;
      logic signed [LIM_W-1:0]  upper_limit;
      logic signed [LIM_W-1:0]  lower_limit;
   } trk_type;

   // add a knob step to a limit, saturating at the signed 32-bit range
   function automatic logic signed [LIM_W-1:0] lim_step(
      input logic signed [LIM_W-1:0]   lim,
      input logic signed [DELTA_W-1:0] delta
   );
      logic signed [LIM_W:0] sum;
      logic signed [LIM_W-1:0] res;
      sum = (LIM_W+1)'(lim) + (LIM_W+1)'(delta);
      if (sum[LIM_W] != sum[LIM_W-1]) begin
         res = sum[LIM_W] ? {1'b1, {(LIM_W-1){1'b0}}} : {1'b0, {(LIM_W-1){1'b1}}};
      end else begin
         res = sum[LIM_W-1:0];
      end
      return res;
   endfunction

   // result code of the edit state
   function automatic logic [1:0] edit_code(input edit_type st);
      logic [1:0] code;
      case (st)
         EDIT_HIGH: code = EDIT_CODE_HIGH;
         EDIT_LOW:  code = EDIT_CODE_LOW;
         default:   code = EDIT_CODE_IDLE;
      endcase
      return code;
   endfunction

endpackage

>>> rtl/gauge_limit_monitor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gauge_limit_monitor_unit: gauge reading limit monitor
// Scales an encoder reading, applies tare, tracks extremes, runs the knob
// limit editor and classes the reading green, yellow or red.
//
//   channel | handshake                | payload
//   --------+--------------------------+-------------------------------------
//   req     | req_tvalid / req_tready  | req_tdata  : reading and events
//   rsp     | rsp_tvalid / rsp_tready  | rsp_tdata  : one result per request
//   csr     | csr_wr_en                | csr_wr_data: gain, Q16.16
//
// One request per cycle unless a result is stalled; a request passes the
// input register, multiplier, state update, divide-by-ten multiplier and
// result register before its result appears.
// The five stages advance together; while a result waits on rsp_tready the
// whole pipe holds and req_tready is low.
// Reset is synchronous; it clears the state, sets the gain to 1.0 and
// empties the pipe.
// ----------------------------------------------------------------------------
module gauge_limit_monitor_unit #(
   parameter int POSITION_BITS = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   // request: [23:0] position, [24] mode_click, [25] tare_click,
   // [26] knob_click, [27] knob_right, [28] knob_left,
   // [29] knob_right_held, [30] knob_left_held, [31] zero
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [glm_pkg::IN_TDATA_W-1:0]  req_tdata,
   // result: [40:0] measured, [81:41] peak_high, [122:82] peak_low,
   // [124:123] zone, [126:125] edit_state, [127] dynamic_on,
   // [159:128] upper_limit, [191:160] lower_limit
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [glm_pkg::OUT_TDATA_W-1:0] rsp_tdata,
   // gain register
   input  logic                            csr_wr_en,
   input  logic [glm_pkg::GAIN_W-1:0]      csr_wr_data
);
   import glm_pkg::*;

   // reading bits that reach the scaler
   localparam int PosUsed = (POSITION_BITS < POS_W) ? POSITION_BITS : POS_W;

   logic                 adv;
   logic [GAIN_W-1:0]    gain_ff, gain_in;
   logic [PosUsed-1:0]   pos_ff;
   evt_type              evt_ff, evt_in;
   logic                 valid_ff;
   logic                 scl_valid;
   logic [SCALED_W-1:0]  scl_value;
   evt_type              scl_evt;
   logic                 trk_valid;
   trk_type              trk;
   logic                 res_valid;
   trk_type              res;
   logic [1:0]           res_zone;

   // pipe moves when the result register is free or being drained
   assign adv        = ~res_valid | rsp_tready;
   assign req_tready = adv & ~reset;

   // gain register
   assign gain_in = csr_wr_en ? csr_wr_data : gain_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
      end else begin
         gain_ff <= gain_in;
      end
   end

   // request unpacking
   always_comb begin
      evt_in.mode_click      = req_tdata[IN_MODE_BIT];
      evt_in.tare_click      = req_tdata[IN_TARE_BIT];
      evt_in.knob_click      = req_tdata[IN_CLICK_BIT];
      evt_in.knob_right      = req_tdata[IN_R_BIT];
      evt_in.knob_left       = req_tdata[IN_L_BIT];
      evt_in.knob_right_held = req_tdata[IN_RH_BIT];
      evt_in.knob_left_held  = req_tdata[IN_LH_BIT];
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pos_ff <= req_tdata[PosUsed-1:0];
         evt_ff <= evt_in;
      end
   end

   glm_scale #(
      .POS_BITS (PosUsed)
   ) u_scale (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (valid_ff),
      .pos       (pos_ff),
      .in_evt    (evt_ff),
      .gain      (gain_ff),
      .out_valid (scl_valid),
      .scaled    (scl_value),
      .out_evt   (scl_evt)
   );

   glm_track u_track (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (scl_valid),
      .scaled    (scl_value),
      .evt       (scl_evt),
      .out_valid (trk_valid),
      .trk       (trk)
   );

   glm_zone u_zone (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (trk_valid),
      .in_trk    (trk),
      .out_valid (res_valid),
      .out_trk   (res),
      .out_zone  (res_zone)
   );

   // result packing
   assign rsp_tvalid = res_valid;
   assign rsp_tdata  = {res.lower_limit, res.upper_limit, res.dynamic_on,
                        res.edit_state, res_zone, res.peak_low, res.peak_high,
                        res.measured};

endmodule

>>> rtl/glm_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glm_scale: reading scaler
// Multiplies the encoder reading by the Q16.16 gain and drops the fraction.
// One registered stage.
// ----------------------------------------------------------------------------
module glm_scale #(
   parameter int POS_BITS = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  logic                           in_valid,
   input  logic [POS_BITS-1:0]            pos,
   input  glm_pkg::evt_type               in_evt,
   input  logic [glm_pkg::GAIN_W-1:0]     gain,
   output logic                           out_valid,
   output logic [glm_pkg::SCALED_W-1:0]   scaled,
   output glm_pkg::evt_type               out_evt
);
   import glm_pkg::*;

   localparam int ProdW = POS_BITS + GAIN_W;

   logic [ProdW-1:0]    prod;
   logic [SCALED_W-1:0] scaled_in;
   logic [SCALED_W-1:0] scaled_ff;
   evt_type             evt_ff;
   logic                valid_ff;

   // product never exceeds 40 bits after the shift for readings up to 24 bits
   assign prod      = ProdW'(pos) * ProdW'(gain);
   assign scaled_in = SCALED_W'(prod[ProdW-1:16]);

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (adv) begin
         scaled_ff <= scaled_in;
         evt_ff    <= in_evt;
      end
   end

   assign out_valid = valid_ff;
   assign scaled    = scaled_ff;
   assign out_evt   = evt_ff;

endmodule

>>> rtl/glm_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glm_track: tare, extremes and limit editor
// Holds the monitor state. Each request forms the measured value, updates
// the extremes, applies a tare, the mode toggle and the knob editor.
// ----------------------------------------------------------------------------
module glm_track (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_valid,
   input  logic [glm_pkg::SCALED_W-1:0] scaled,
   input  glm_pkg::evt_type             evt,
   output logic                         out_valid,
   output glm_pkg::trk_type             trk
);
   import glm_pkg::*;

   logic [SCALED_W-1:0]       tare_ff, tare_in;
   logic signed [MEAS_W-1:0]  max_ff, max_in;
   logic signed [MEAS_W-1:0]  min_ff, min_in;
   logic signed [LIM_W-1:0]   high_ff, high_in;
   logic signed [LIM_W-1:0]   low_ff, low_in;
   edit_type                  edit_ff, edit_in;
   logic                      dyn_ff, dyn_in;
   logic signed [MEAS_W-1:0]  meas;
   logic signed [DELTA_W-1:0] delta;
   logic                      step_en;
   trk_type                   trk_ff, trk_in;
   logic                      valid_ff;

   assign step_en = adv & in_valid;

   // measured value against the offset in force before this request
   assign meas = $signed({1'b0, scaled}) - $signed({1'b0, tare_ff});

   // net knob movement of this request
   always_comb begin
      delta = '0;
      if (evt.knob_right)      delta = delta + DELTA_W'(1);
      if (evt.knob_left)       delta = delta - DELTA_W'(1);
      if (evt.knob_right_held) delta = delta + DELTA_W'(10);
      if (evt.knob_left_held)  delta = delta - DELTA_W'(10);
   end

   // next state
   always_comb begin
      max_in  = (meas > max_ff) ? meas : max_ff;
      min_in  = (meas < min_ff) ? meas : min_ff;
      tare_in = tare_ff;
      dyn_in  = dyn_ff ^ evt.mode_click;
      if (evt.tare_click) begin
         tare_in = scaled;
         max_in  = '0;
         min_in  = '0;
      end
      high_in = high_ff;
      low_in  = low_ff;
      edit_in = edit_ff;
      // turns go to the limit edited before this click, or high from idle
      case (edit_ff)
         EDIT_IDLE: begin
            if (evt.knob_click) begin
               edit_in = EDIT_HIGH;
               high_in = lim_step(high_ff, delta);
            end
         end
         EDIT_HIGH: begin
            high_in = lim_step(high_ff, delta);
            if (evt.knob_click) edit_in = EDIT_LOW;
         end
         EDIT_LOW: begin
            low_in = lim_step(low_ff, delta);
            if (evt.knob_click) edit_in = EDIT_IDLE;
         end
         default: edit_in = EDIT_IDLE;
      endcase
   end

   // result of this request
   always_comb begin
      trk_in.measured    = meas;
      trk_in.peak_high   = max_in;
      trk_in.peak_low    = min_in;
      trk_in.edit_state  = edit_code(edit_in);
      trk_in.dynamic_on  = dyn_in;
      trk_in.upper_limit = high_in;
      trk_in.lower_limit = low_in;
   end

   // monitor state
   always_ff @(posedge clock) begin
      if (reset) begin
         tare_ff <= '0;
         max_ff  <= '0;
         min_ff  <= '0;
         high_ff <= '0;
         low_ff  <= '0;
         edit_ff <= EDIT_IDLE;
         dyn_ff  <= 1'b0;
      end else if (step_en) begin
         tare_ff <= tare_in;
         max_ff  <= max_in;
         min_ff  <= min_in;
         high_ff <= high_in;
         low_ff  <= low_in;
         edit_ff <= edit_in;
         dyn_ff  <= dyn_in;
      end
   end

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (adv) begin
         trk_ff <= trk_in;
      end
   end

   assign out_valid = valid_ff;
   assign trk       = trk_ff;

endmodule

>>> rtl/glm_zone.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glm_zone: zone classifier and result register
// Stage one divides both limits by ten (reciprocal multiply on magnitudes),
// stage two forms the warning thresholds, classes the measured value and
// holds the result.
// ----------------------------------------------------------------------------
module glm_zone (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_valid,
   input  glm_pkg::trk_type in_trk,
   output logic             out_valid,
   output glm_pkg::trk_type out_trk,
   output logic [1:0]       out_zone
);
   import glm_pkg::*;

   logic [LIM_W-1:0]         high_mag, low_mag;
   logic [2*LIM_W-1:0]       high_prod, low_prod;
   logic [QUOT_W-1:0]        hq_ff, lq_ff;
   trk_type                  trk_a_ff;
   logic                     valid_a_ff;
   logic signed [LIM_W:0]    hq_s, lq_s;
   logic signed [LIM_W:0]    hwarn, lwarn;
   logic signed [MEAS_W:0]   meas_x, high_x, low_x, hwarn_x, lwarn_x;
   logic [1:0]               zone_in;
   logic [1:0]               zone_ff;
   trk_type                  trk_ff;
   logic                     valid_ff;

   // magnitudes of the limits; the most negative limit maps to 2^31
   assign high_mag  = in_trk.upper_limit[LIM_W-1] ? LIM_W'(-in_trk.upper_limit)
                                                  : LIM_W'(in_trk.upper_limit);
   assign low_mag   = in_trk.lower_limit[LIM_W-1] ? LIM_W'(-in_trk.lower_limit)
                                                  : LIM_W'(in_trk.lower_limit);
   assign high_prod = (2*LIM_W)'(high_mag) * (2*LIM_W)'(RECIP10);
   assign low_prod  = (2*LIM_W)'(low_mag) * (2*LIM_W)'(RECIP10);

   // stage one valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else if (adv) begin
         valid_a_ff <= in_valid;
      end
   end

   // stage one payload
   always_ff @(posedge clock) begin
      if (adv) begin
         hq_ff    <= high_prod[RECIP_SHIFT +: QUOT_W];
         lq_ff    <= low_prod[RECIP_SHIFT +: QUOT_W];
         trk_a_ff <= in_trk;
      end
   end

   // signed quotients, truncated toward zero, and warning thresholds
   always_comb begin
      hq_s = $signed({{(LIM_W+1-QUOT_W){1'b0}}, hq_ff});
      lq_s = $signed({{(LIM_W+1-QUOT_W){1'b0}}, lq_ff});
      if (trk_a_ff.upper_limit[LIM_W-1]) hq_s = -hq_s;
      if (trk_a_ff.lower_limit[LIM_W-1]) lq_s = -lq_s;
      hwarn   = (LIM_W+1)'(trk_a_ff.upper_limit) - hq_s;
      lwarn   = (LIM_W+1)'(trk_a_ff.lower_limit) + lq_s;
      meas_x  = (MEAS_W+1)'(trk_a_ff.measured);
      high_x  = (MEAS_W+1)'(trk_a_ff.upper_limit);
      low_x   = (MEAS_W+1)'(trk_a_ff.lower_limit);
      hwarn_x = (MEAS_W+1)'(hwarn);
      lwarn_x = (MEAS_W+1)'(lwarn);
   end

   // classification
   always_comb begin
      if (meas_x >= high_x || meas_x <= low_x) begin
         zone_in = ZONE_RED;
      end else if (meas_x >= hwarn_x || meas_x <= lwarn_x) begin
         zone_in = ZONE_YELLOW;
      end else begin
         zone_in = ZONE_GREEN;
      end
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_a_ff;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (adv) begin
         trk_ff  <= trk_a_ff;
         zone_ff <= zone_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_trk   = trk_ff;
   assign out_zone  = zone_ff;

endmodule

>>> rtl/glm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glm_checker: port checks for the gauge limit monitor
// Watches the top-level ports: result hold under stall, backpressure to the
// request side, reset behavior and the sign of the extremes.
// ----------------------------------------------------------------------------
module glm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [glm_pkg::OUT_TDATA_W-1:0] rsp_tdata
);
   import glm_pkg::*;

   logic stalled;
   logic peak_high_neg;
   logic peak_low_pos;

   assign stalled       = rsp_tvalid & ~rsp_tready;
   assign peak_high_neg = rsp_tdata[81];
   assign peak_low_pos  = ~rsp_tdata[122] & (rsp_tdata[122:82] != '0);

   // a waiting result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      stalled |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // a waiting result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      stalled |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

   // a stalled result blocks new requests
   a_backpressure: assert property (@(posedge clock)
      stalled |-> !req_tready)
      else $error("request taken while result stalled");

   // reset empties the pipe
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // extremes start at zero after reset and every tare, so keep their sign
   a_peak_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!peak_high_neg && !peak_low_pos))
      else $error("extreme on the wrong side of zero");

endmodule

bind gauge_limit_monitor_unit glm_checker u_glm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
